FILE: rtl/core/sm83_pkg.sv
package sm83_pkg;

  localparam int unsigned OpW    = 6;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdW = 3;
  localparam int unsigned FlagW  = 4;

  // Flag positions inside a flag nibble.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Decimal adjust constants.
  localparam logic [ByteW-1:0] DaaLoAdj = 8'h06;
  localparam logic [ByteW-1:0] DaaHiAdj = 8'h60;
  localparam logic [ByteW-1:0] DaaLimit = 8'h99;
  localparam logic [3:0]       DaaNibMax = 4'h9;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [FlagW-1:0]  flags_t;
  typedef logic [BitIdW-1:0] bit_idx_t;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 6'd0,
    OP_ADC   = 6'd1,
    OP_SUB   = 6'd2,
    OP_SBC   = 6'd3,
    OP_AND   = 6'd4,
    OP_XOR   = 6'd5,
    OP_OR    = 6'd6,
    OP_CP    = 6'd7,
    OP_INC8  = 6'd8,
    OP_DEC8  = 6'd9,
    OP_INC16 = 6'd10,
    OP_DEC16 = 6'd11,
    OP_ADD16 = 6'd12,
    OP_ADDSP = 6'd13,
    OP_RLCA  = 6'd14,
    OP_RRCA  = 6'd15,
    OP_RLA   = 6'd16,
    OP_RRA   = 6'd17,
    OP_DAA   = 6'd18,
    OP_CPL   = 6'd19,
    OP_SCF   = 6'd20,
    OP_CCF   = 6'd21,
    OP_RLC   = 6'd22,
    OP_RRC   = 6'd23,
    OP_RL    = 6'd24,
    OP_RR    = 6'd25,
    OP_SLA   = 6'd26,
    OP_SRA   = 6'd27,
    OP_SWAP  = 6'd28,
    OP_SRL   = 6'd29,
    OP_BIT   = 6'd30,
    OP_RES   = 6'd31,
    OP_SET   = 6'd32
  } op_e;

endpackage

FILE: rtl/core/sm83_if.sv
interface sm83_req_if;
  import sm83_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpW-1:0]        op;
  logic [WordW-1:0]      operand_a;
  logic [WordW-1:0]      operand_b;
  logic [BitIdW-1:0]     bit_index;
  logic [FlagW-1:0]      flags_in;

  modport source (
    output valid, op, operand_a, operand_b, bit_index, flags_in,
    input  ready
  );

  modport sink (
    input  valid, op, operand_a, operand_b, bit_index, flags_in,
    output ready
  );
endinterface

interface sm83_rsp_if;
  import sm83_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] result;
  logic [FlagW-1:0] flags_out;

  modport source (
    output valid, result, flags_out,
    input  ready
  );

  modport sink (
    input  valid, result, flags_out,
    output ready
  );
endinterface

FILE: rtl/core/sm83_alu_flags_unit.sv
// Path: an accepted word is captured in the input register, moves into the
// result register when that register is empty or being emptied, and is
// offered on the result channel from the result register.
// Throughput: one word per cycle while results are taken; the result register
// frees in the same cycle it is taken, so back-to-back words never bubble.
// Reset (rst_ni low, asynchronous) empties both stages; payload is not reset.
module sm83_alu_flags_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sm83_req_if.sink   req_i,
  sm83_rsp_if.source rsp_o
);
  import sm83_pkg::*;

  // ---------------------------------------------------------------------
  // Stage control. Stage 1 holds the captured operands, stage 2 holds the
  // finished result. Stage 1 moves into stage 2 whenever stage 2 is empty
  // or its word is being taken this cycle, and stage 1 accepts a new word
  // whenever it is empty or moving on.
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic s1_adv;
  logic req_fire;

  assign s1_adv      = s1_valid_q && (!s2_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;

  assign s1_valid_d = req_fire || (s1_valid_q && !s1_adv);
  assign s2_valid_d = s1_adv || (s2_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register: operands captured on acceptance.
  logic [OpW-1:0] s1_op_q;
  word_t          s1_a_q;
  word_t          s1_b_q;
  bit_idx_t       s1_bi_q;
  flags_t         s1_fl_q;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q <= req_i.op;
      s1_a_q  <= req_i.operand_a;
      s1_b_q  <= req_i.operand_b;
      s1_bi_q <= req_i.bit_index;
      s1_fl_q <= req_i.flags_in;
    end
  end

  // ---------------------------------------------------------------------
  // ALU proper. The 8-bit operations work on the low bytes and return a
  // result with a zero upper byte. Narrow adders carry one extra bit so
  // that carry and borrow fall out of the top bit directly.
  // ---------------------------------------------------------------------
  logic [ByteW-1:0] a8;
  logic [ByteW-1:0] b8;
  logic             zi, ni, hi, ci;
  logic             use_c;
  logic [ByteW:0]   add9;
  logic [4:0]       addh;
  logic [ByteW:0]   sub9;
  logic [4:0]       subh;
  logic [WordW:0]   add17;
  logic [12:0]      add13;
  logic [ByteW:0]   sp_lo9;
  logic [4:0]       sp_h5;
  logic [ByteW-1:0] daa_adj;
  logic             daa_c;
  logic [ByteW-1:0] bit_mask;
  logic [ByteW-1:0] r8;
  word_t            alu_result;
  flags_t           alu_flags;

  assign a8 = s1_a_q[ByteW-1:0];
  assign b8 = s1_b_q[ByteW-1:0];
  assign zi = s1_fl_q[FlagZ];
  assign ni = s1_fl_q[FlagN];
  assign hi = s1_fl_q[FlagH];
  assign ci = s1_fl_q[FlagC];

  // Carry-in is used by adc and sbc only.
  assign use_c = ci && ((op_e'(s1_op_q) == OP_ADC) || (op_e'(s1_op_q) == OP_SBC));

  assign add9  = {1'b0, a8} + {1'b0, b8} + {8'd0, use_c};
  assign addh  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, use_c};
  assign sub9  = {1'b0, a8} - {1'b0, b8} - {8'd0, use_c};
  assign subh  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, use_c};
  assign add17 = {1'b0, s1_a_q} + {1'b0, s1_b_q};
  assign add13 = {1'b0, s1_a_q[11:0]} + {1'b0, s1_b_q[11:0]};

  // Stack pointer plus signed byte: flags come from the unsigned low parts.
  assign sp_lo9 = {1'b0, s1_a_q[ByteW-1:0]} + {1'b0, b8};
  assign sp_h5  = {1'b0, s1_a_q[3:0]} + {1'b0, b8[3:0]};

  // Decimal adjust: after a subtraction only the incoming H and C decide.
  always_comb begin
    daa_adj = '0;
    daa_c   = 1'b0;
    if (hi || (!ni && (a8[3:0] > DaaNibMax))) begin
      daa_adj = DaaLoAdj;
    end
    if (ci || (!ni && (a8 > DaaLimit))) begin
      daa_adj = daa_adj | DaaHiAdj;
      daa_c   = 1'b1;
    end
  end

  assign bit_mask = ByteW'(1) << s1_bi_q;

  always_comb begin
    r8         = '0;
    alu_result = s1_a_q;
    alu_flags  = s1_fl_q;
    unique case (op_e'(s1_op_q))
      OP_ADD, OP_ADC: begin
        r8         = add9[ByteW-1:0];
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 1'b0, addh[4], add9[ByteW]};
      end
      OP_SUB, OP_SBC: begin
        r8         = sub9[ByteW-1:0];
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 1'b1, subh[4], sub9[ByteW]};
      end
      OP_CP: begin
        r8         = sub9[ByteW-1:0];
        alu_result = {8'd0, a8};
        alu_flags  = {r8 == '0, 1'b1, subh[4], sub9[ByteW]};
      end
      OP_AND: begin
        r8         = a8 & b8;
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8         = a8 ^ b8;
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 3'b000};
      end
      OP_OR: begin
        r8         = a8 | b8;
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 3'b000};
      end
      OP_INC8: begin
        r8         = a8 + 8'd1;
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 1'b0, r8[3:0] == 4'h0, ci};
      end
      OP_DEC8: begin
        r8         = a8 - 8'd1;
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 1'b1, r8[3:0] == 4'hF, ci};
      end
      OP_INC16: alu_result = s1_a_q + 16'd1;
      OP_DEC16: alu_result = s1_a_q - 16'd1;
      OP_ADD16: begin
        alu_result = add17[WordW-1:0];
        alu_flags  = {zi, 1'b0, add13[12], add17[WordW]};
      end
      OP_ADDSP: begin
        alu_result = s1_a_q + {{8{b8[7]}}, b8};
        alu_flags  = {2'b00, sp_h5[4], sp_lo9[ByteW]};
      end
      OP_RLCA: begin
        alu_result = {8'd0, a8[6:0], a8[7]};
        alu_flags  = {3'b000, a8[7]};
      end
      OP_RRCA: begin
        alu_result = {8'd0, a8[0], a8[7:1]};
        alu_flags  = {3'b000, a8[0]};
      end
      OP_RLA: begin
        alu_result = {8'd0, a8[6:0], ci};
        alu_flags  = {3'b000, a8[7]};
      end
      OP_RRA: begin
        alu_result = {8'd0, ci, a8[7:1]};
        alu_flags  = {3'b000, a8[0]};
      end
      OP_DAA: begin
        r8         = ni ? (a8 - daa_adj) : (a8 + daa_adj);
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, ni, 1'b0, daa_c};
      end
      OP_CPL: begin
        alu_result = {8'd0, ~a8};
        alu_flags  = {zi, 1'b1, 1'b1, ci};
      end
      OP_SCF: begin
        alu_result = {8'd0, a8};
        alu_flags  = {zi, 1'b0, 1'b0, 1'b1};
      end
      OP_CCF: begin
        alu_result = {8'd0, a8};
        alu_flags  = {zi, 1'b0, 1'b0, !ci};
      end
      OP_RLC: begin
        r8         = {a8[6:0], a8[7]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[7]};
      end
      OP_RRC: begin
        r8         = {a8[0], a8[7:1]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[0]};
      end
      OP_RL: begin
        r8         = {a8[6:0], ci};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[7]};
      end
      OP_RR: begin
        r8         = {ci, a8[7:1]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[0]};
      end
      OP_SLA: begin
        r8         = {a8[6:0], 1'b0};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[7]};
      end
      OP_SRA: begin
        r8         = {a8[7], a8[7:1]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[0]};
      end
      OP_SWAP: begin
        r8         = {a8[3:0], a8[7:4]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 3'b000};
      end
      OP_SRL: begin
        r8         = {1'b0, a8[7:1]};
        alu_result = {8'd0, r8};
        alu_flags  = {r8 == '0, 2'b00, a8[0]};
      end
      OP_BIT: begin
        alu_result = {8'd0, a8};
        alu_flags  = {(a8 & bit_mask) == '0, 1'b0, 1'b1, ci};
      end
      OP_RES: alu_result = {8'd0, a8 & ~bit_mask};
      OP_SET: alu_result = {8'd0, a8 | bit_mask};
      // Unassigned codes pass operand A and the flags through untouched.
      default: begin
        alu_result = s1_a_q;
        alu_flags  = s1_fl_q;
      end
    endcase
  end

  // Result register: loaded whenever stage 1 advances.
  word_t  res_q;
  flags_t flg_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= alu_result;
      flg_q <= alu_flags;
    end
  end

  assign rsp_o.valid     = s2_valid_q;
  assign rsp_o.result    = res_q;
  assign rsp_o.flags_out = flg_q;

  // ---------------------------------------------------------------------
  // Checks on the pipeline and on a few operation contracts.
  // ---------------------------------------------------------------------
  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> s1_valid_q)
    else $error("accepted word did not reach the input register");

  a_adv_fills_s2 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (s2_valid_q && (res_q == $past(alu_result))))
    else $error("result register did not take the advancing word");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_op_q) && $stable(s1_a_q)))
    else $error("stalled input register lost or changed its word");

  a_cp_keeps_a : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (op_e'(s1_op_q) == OP_CP)) |-> (alu_result == {8'd0, a8}))
    else $error("compare altered the accumulator");

  a_wide_incdec_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && ((op_e'(s1_op_q) == OP_INC16) || (op_e'(s1_op_q) == OP_DEC16)))
    |-> (alu_flags == s1_fl_q))
    else $error("16-bit increment or decrement changed the flags");

endmodule

FILE: verif/sm83_alu_flags_unit_tb.sv
`timescale 1ns / 100ps

module sm83_alu_flags_unit_tb;
  import sm83_pkg::*;

  // Operation codes past OP_SET decode to nothing; the unit passes the word through.
  localparam logic [OpW-1:0] OpUnusedLo = 6'd33;
  localparam logic [OpW-1:0] OpUnusedHi = 6'd63;

  localparam int RandomWords = 815;
  localparam int CalmFrom    = 150;  // no idling on either side between these counts
  localparam int CalmTo      = 350;
  localparam int HoldAt      = 450;  // result count at which the sink stops taking words
  localparam int HoldCycles  = 64;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 8;
  localparam int PrintLimit  = 100;

  typedef struct packed {
    logic [OpW-1:0] op;
    word_t          a;
    word_t          b;
    bit_idx_t       bit_idx;
    flags_t         flags;
  } alu_word_t;

  typedef struct packed {
    word_t  result;
    flags_t flags;
  } alu_out_t;

  // An expected result keeps the word that caused it, so a mismatch can name its source.
  typedef struct packed {
    alu_word_t src;
    alu_out_t  out;
  } alu_expect_t;

  logic clk_i;
  logic rst_ni;

  sm83_req_if req_if ();
  sm83_rsp_if rsp_if ();

  sm83_alu_flags_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  alu_word_t   stim_q[$];     // words still to be offered to the unit
  alu_expect_t result_q[$];   // results owed by the unit, oldest first
  alu_word_t   cur_word;      // word currently on the request channel
  int          words_sent   = 0;
  int          results_seen = 0;
  int          err_cnt      = 0;
  int          stall_cycles = 0;
  int          hold_left    = 0;
  bit          hold_done    = 1'b0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Flag and result helpers for the predictor.
  // ---------------------------------------------------------------------------
  function automatic flags_t pack_flags(logic z, logic n, logic h, logic c);
    flags_t f;
    f        = '0;
    f[FlagZ] = z;
    f[FlagN] = n;
    f[FlagH] = h;
    f[FlagC] = c;
    return f;
  endfunction

  // Byte-wide operations return a result whose upper byte is zero.
  function automatic alu_out_t byte_out(logic [ByteW-1:0] r, flags_t f);
    alu_out_t o;
    o.result = {8'h00, r};
    o.flags  = f;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: the result and flags the ALU should produce for one word.
  // Anything not handled below (16-bit inc/dec flags, res/set flags and the
  // unused codes) keeps the incoming value.
  // ---------------------------------------------------------------------------
  function automatic alu_out_t alu_predict(alu_word_t w);
    logic [ByteW-1:0] a, b, r, adj;
    logic [8:0]       sum9;
    logic [4:0]       nib;
    logic [16:0]      sum17;
    logic [12:0]      sum13;
    logic             zi, ni, hi, ci, cx, cf;
    alu_out_t         o;
    a        = w.a[7:0];
    b        = w.b[7:0];
    zi       = w.flags[FlagZ];
    ni       = w.flags[FlagN];
    hi       = w.flags[FlagH];
    ci       = w.flags[FlagC];
    o.result = w.a;
    o.flags  = w.flags;
    case (w.op)
      OP_ADD, OP_ADC: begin
        cx   = (w.op == OP_ADC) && ci;
        sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cx};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cx};
        o    = byte_out(sum9[7:0], pack_flags(sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]));
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // A borrow out of the nibble or the byte shows up as the top bit of
        // the widened difference. Compare keeps the accumulator.
        cx   = (w.op == OP_SBC) && ci;
        sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cx};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cx};
        o    = byte_out((w.op == OP_CP) ? a : sum9[7:0],
                        pack_flags(sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]));
      end
      OP_AND: o = byte_out(a & b, pack_flags((a & b) == 8'h00, 1'b0, 1'b1, 1'b0));
      OP_XOR: o = byte_out(a ^ b, pack_flags((a ^ b) == 8'h00, 1'b0, 1'b0, 1'b0));
      OP_OR:  o = byte_out(a | b, pack_flags((a | b) == 8'h00, 1'b0, 1'b0, 1'b0));
      OP_INC8: begin
        r = a + 8'd1;
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, r[3:0] == 4'h0, ci));
      end
      OP_DEC8: begin
        r = a - 8'd1;
        o = byte_out(r, pack_flags(r == 8'h00, 1'b1, r[3:0] == 4'hF, ci));
      end
      OP_INC16: o.result = w.a + 16'd1;
      OP_DEC16: o.result = w.a - 16'd1;
      OP_ADD16: begin
        sum17    = {1'b0, w.a} + {1'b0, w.b};
        sum13    = {1'b0, w.a[11:0]} + {1'b0, w.b[11:0]};
        o.result = sum17[15:0];
        o.flags  = pack_flags(zi, 1'b0, sum13[12], sum17[16]);
      end
      OP_ADDSP: begin
        // The displacement is signed, but H and C come from unsigned adds of
        // the low nibble and the low byte.
        nib      = {1'b0, w.a[3:0]} + {1'b0, b[3:0]};
        sum9     = {1'b0, w.a[7:0]} + {1'b0, b};
        o.result = w.a + {{8{b[7]}}, b};
        o.flags  = pack_flags(1'b0, 1'b0, nib[4], sum9[8]);
      end
      OP_RLCA: o = byte_out({a[6:0], a[7]}, pack_flags(1'b0, 1'b0, 1'b0, a[7]));
      OP_RRCA: o = byte_out({a[0], a[7:1]}, pack_flags(1'b0, 1'b0, 1'b0, a[0]));
      OP_RLA:  o = byte_out({a[6:0], ci}, pack_flags(1'b0, 1'b0, 1'b0, a[7]));
      OP_RRA:  o = byte_out({ci, a[7:1]}, pack_flags(1'b0, 1'b0, 1'b0, a[0]));
      OP_DAA: begin
        adj = 8'h00;
        cf  = 1'b0;
        if (hi || (!ni && a[3:0] > DaaNibMax)) adj = DaaLoAdj;
        if (ci || (!ni && a > DaaLimit)) begin
          adj = adj | DaaHiAdj;
          cf  = 1'b1;
        end
        r = ni ? a - adj : a + adj;
        o = byte_out(r, pack_flags(r == 8'h00, ni, 1'b0, cf));
      end
      OP_CPL: o = byte_out(~a, pack_flags(zi, 1'b1, 1'b1, ci));
      OP_SCF: o = byte_out(a, pack_flags(zi, 1'b0, 1'b0, 1'b1));
      OP_CCF: o = byte_out(a, pack_flags(zi, 1'b0, 1'b0, !ci));
      OP_RLC: begin
        r = {a[6:0], a[7]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]));
      end
      OP_RRC: begin
        r = {a[0], a[7:1]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]));
      end
      OP_RL: begin
        r = {a[6:0], ci};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]));
      end
      OP_RR: begin
        r = {ci, a[7:1]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]));
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[7]));
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]));
      end
      OP_SWAP: begin
        r = {a[3:0], a[7:4]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0));
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        o = byte_out(r, pack_flags(r == 8'h00, 1'b0, 1'b0, a[0]));
      end
      OP_BIT: o = byte_out(a, pack_flags(!a[w.bit_idx], 1'b0, 1'b1, ci));
      OP_RES: begin
        r             = a;
        r[w.bit_idx]  = 1'b0;
        o.result      = {8'h00, r};
      end
      OP_SET: begin
        r             = a;
        r[w.bit_idx]  = 1'b1;
        o.result      = {8'h00, r};
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [OpW-1:0] op, word_t a, word_t b, bit_idx_t bi, flags_t fl);
    stim_q.push_back('{op: op, a: a, b: b, bit_idx: bi, flags: fl});
  endtask

  // Operands lean toward the byte values where carries, borrows, the BCD
  // limits and sign bits flip; the upper byte stays random either way.
  function automatic word_t pick_operand();
    logic [ByteW-1:0] lo;
    if ($urandom_range(9) < 6) return word_t'($urandom);
    case ($urandom_range(7))
      0:       lo = 8'h00;
      1:       lo = 8'hFF;
      2:       lo = 8'h0F;
      3:       lo = 8'hF0;
      4:       lo = 8'h80;
      5:       lo = 8'h7F;
      6:       lo = 8'h99;
      default: lo = 8'h01;
    endcase
    return {8'($urandom), lo};
  endfunction

  // Both sides idle about a quarter of the time, except in one calm stretch.
  function automatic int idle_pct(int n);
    return (n >= CalmFrom && n < CalmTo) ? 0 : 25;
  endfunction

  task automatic report_mismatch(string what, alu_word_t src, word_t got, word_t want);
    if (err_cnt < PrintLimit)
      $display("%0t MISMATCH %s: op=%0d a=%h b=%h bit=%0d flags=%h got=%h want=%h",
               $realtime, what, src.op, src.a, src.b, src.bit_idx, src.flags, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver. A word is taken when valid and ready are both high at an edge;
  // its expected result is queued right then. A new word (or an idle cycle)
  // is chosen only once the current one is gone, so valid gets at most one
  // update per edge and never drops while a word waits.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        result_q.push_back('{src: cur_word, out: alu_predict(cur_word)});
        words_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= idle_pct(words_sent)) begin
          cur_word            = stim_q.pop_front();
          req_if.op          <= cur_word.op;
          req_if.operand_a   <= cur_word.a;
          req_if.operand_b   <= cur_word.b;
          req_if.bit_index   <= cur_word.bit_idx;
          req_if.flags_in    <= cur_word.flags;
          req_if.valid       <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result taken is matched against the oldest expectation,
  // field by field. Ready is random, except for one long hold-off partway
  // through: the unit's two stages fill, its input stalls, and the driver
  // keeps its word on offer the whole time.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, rsp_if.result, '0);
        end else begin
          if (rsp_if.result !== result_q[0].out.result)
            report_mismatch("result", result_q[0].src, rsp_if.result, result_q[0].out.result);
          if (rsp_if.flags_out !== result_q[0].out.flags)
            report_mismatch("flags", result_q[0].src, word_t'(rsp_if.flags_out),
                            word_t'(result_q[0].out.flags));
          void'(result_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct(results_seen));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles with no word moving on either channel means the
  // unit has hung. The limit is far above the hold-off and any random gap.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("sm83_alu_flags_unit_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [OpW-1:0] op;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.op        = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    req_if.bit_index = '0;
    req_if.flags_in  = '0;
    rsp_if.ready     = 1'b0;

    // Directed words: at least one per operation, each aimed at its interesting corner.
    // Upper operand bytes are set on some byte operations to show they are dropped.
    push_word(OP_ADD,   16'hA5FF, 16'h5A01, 3'd0, 4'h0);  // wraps to zero, half and full carry
    push_word(OP_ADC,   16'h000F, 16'h0000, 3'd0, 4'h1);  // carry in ripples into bit 4
    push_word(OP_SUB,   16'h0000, 16'h0001, 3'd0, 4'h0);  // borrow from both nibble and byte
    push_word(OP_SBC,   16'h0010, 16'h000F, 3'd0, 4'h1);  // zero result, half borrow but no full borrow
    push_word(OP_AND,   16'hFFF0, 16'hFF0F, 3'd0, 4'hF);
    push_word(OP_XOR,   16'h00FF, 16'h00FF, 3'd0, 4'h0);
    push_word(OP_OR,    16'hFF00, 16'hFF00, 3'd0, 4'hF);
    push_word(OP_CP,    16'h123C, 16'h003C, 3'd0, 4'h0);  // accumulator comes back unchanged
    push_word(OP_INC8,  16'hFFFF, 16'h0000, 3'd0, 4'h1);
    push_word(OP_DEC8,  16'h0010, 16'h0000, 3'd0, 4'h0);  // half borrow into low nibble
    push_word(OP_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'hA);  // flags pass through
    push_word(OP_DEC16, 16'h0000, 16'h0000, 3'd0, 4'h5);
    push_word(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'hF);  // carries out of bits 11 and 15
    push_word(OP_ADDSP, 16'h00FF, 16'h00FF, 3'd0, 4'hF);  // minus one, unsigned carries set
    push_word(OP_ADDSP, 16'h0000, 16'hFF80, 3'd0, 4'h0);  // most negative displacement
    push_word(OP_RLCA,  16'h0080, 16'h0000, 3'd0, 4'h8);  // zero flag cleared regardless
    push_word(OP_RRCA,  16'h0001, 16'h0000, 3'd0, 4'h0);
    push_word(OP_RLA,   16'h0080, 16'h0000, 3'd0, 4'h8);
    push_word(OP_RRA,   16'h0001, 16'h0000, 3'd0, 4'h1);
    push_word(OP_DAA,   16'h009A, 16'h0000, 3'd0, 4'h0);  // both adjustments after an add
    push_word(OP_DAA,   16'h0000, 16'h0000, 3'd0, 4'h7);  // both adjustments after a subtract
    push_word(OP_CPL,   16'hFF00, 16'h0000, 3'd0, 4'h0);
    push_word(OP_SCF,   16'hAB12, 16'h0000, 3'd0, 4'hE);
    push_word(OP_CCF,   16'h0034, 16'h0000, 3'd0, 4'h1);
    push_word(OP_RLC,   16'h0000, 16'h0000, 3'd0, 4'h0);
    push_word(OP_RRC,   16'h0001, 16'h0000, 3'd0, 4'h0);
    push_word(OP_RL,    16'h0080, 16'h0000, 3'd0, 4'h0);  // shifts out to zero
    push_word(OP_RR,    16'h0001, 16'h0000, 3'd0, 4'h1);
    push_word(OP_SLA,   16'h0080, 16'h0000, 3'd0, 4'h0);
    push_word(OP_SRA,   16'h0081, 16'h0000, 3'd0, 4'h0);
    push_word(OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 4'h0);
    push_word(OP_SRL,   16'h0001, 16'h0000, 3'd0, 4'h0);
    push_word(OP_BIT,   16'h007F, 16'h0000, 3'd7, 4'h1);  // tested bit is clear
    push_word(OP_RES,   16'hFFFF, 16'h0000, 3'd0, 4'h5);
    push_word(OP_SET,   16'h0000, 16'h0000, 3'd7, 4'hA);
    push_word(OpUnusedLo, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF); // passes operand and flags through
    push_word(OpUnusedHi, 16'h5AA5, 16'h0000, 3'd0, 4'h6);

    // Random words, with a small share of unused codes.
    repeat (RandomWords) begin
      if ($urandom_range(9) == 0) op = OpW'($urandom_range(OpUnusedHi, OpUnusedLo));
      else                        op = OpW'($urandom_range(OP_SET, OP_ADD));
      push_word(op, pick_operand(), pick_operand(), bit_idx_t'($urandom), flags_t'($urandom));
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait on the falling edge so the queues have settled after each rising one.
    while (stim_q.size() != 0 || req_if.valid || result_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("sm83_alu_flags_unit_tb: clean");
    end else begin
      $display("sm83_alu_flags_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sm83_pkg.sv
rtl/core/sm83_if.sv
rtl/core/sm83_alu_flags_unit.sv
verif/sm83_alu_flags_unit_tb.sv
